// ----- rtl/hce_pkg.sv -----
// Package for the Hermite curve evaluator: fixed-point constants, result kinds
// and the command/status structs between controller and datapath. No dependencies.
package hce_pkg;
    localparam int unsigned FB = 15;
    localparam logic signed [17:0] ONE = 18'sd32768;
    localparam logic signed [17:0] EPS = 18'sd33;

    localparam logic [2:0] KIND_SEG    = 3'd0;
    localparam logic [2:0] KIND_BELOW  = 3'd1;
    localparam logic [2:0] KIND_ABOVE  = 3'd2;
    localparam logic [2:0] KIND_NARROW = 3'd3;
    localparam logic [2:0] KIND_FEW    = 3'd4;

    typedef struct packed {
        logic start;   // latch sample and begin a search
        logic scan;    // step the segment scan
        logic prep;    // start the dividers for s and both slopes
        logic mul1;    // scaled slopes and s^2
        logic mul2;    // s^3
        logic mul3;    // basis weights times values
        logic fin;     // final sum into the output register
    } t_cmd;

    typedef struct packed {
        logic scan_done;  // the search has a result
        logic special;    // result already known without the Hermite sum
        logic div_done;   // all three dividers are finished
    } t_status;
endpackage

// ----- rtl/hce_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, signed, truncating.
// Uses hce_pkg only for house consistency of widths.
module hce_div import hce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [39:0] i_num,
    input  logic signed [39:0] i_den,
    output logic signed [39:0] o_quo,
    output logic               o_done
);
    logic [39:0] r_q, r_d, r_rem;
    logic        r_neg, r_busy;
    logic [5:0]  r_cnt;
    logic [40:0] n_trial;
    logic [39:0] n_rem;

    assign n_rem   = {r_rem[38:0], r_q[39]};
    assign n_trial = {1'b0, n_rem} - {1'b0, r_d};

    // One shift-subtract step per cycle on magnitudes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd40;
            r_q    <= i_num[39] ? 40'(-i_num) : i_num;
            r_d    <= i_den[39] ? 40'(-i_den) : i_den;
            r_rem  <= '0;
            r_neg  <= i_num[39] ^ i_den[39];
        end else if (r_busy) begin
            if (!n_trial[40]) begin
                r_rem <= n_trial[39:0];
                r_q   <= {r_q[38:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_q   <= {r_q[38:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    assign o_quo  = r_neg ? 40'(-r_q) : r_q;
    assign o_done = !r_busy && !i_start;
endmodule

// ----- rtl/hce_datapath.sv -----
// Datapath: point table, segment scan, dividers, multipliers and output.
// Depends on hce_pkg and hce_div.
module hce_datapath import hce_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  logic [3:0]         i_point_index,
    input  logic [15:0]        i_point_x,
    input  logic [15:0]        i_point_y,
    input  logic signed [15:0] i_tangent_x,
    input  logic signed [15:0] i_tangent_y,
    input  logic [15:0]        i_sample_t,
    input  logic [4:0]         i_point_count,
    input  t_cmd               i_cmd,
    output t_status            o_sts,
    output logic signed [18:0] o_curve_value,
    output logic [2:0]         o_result_kind
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam logic signed [39:0] SL_HI = 40'sd8388607;
    localparam logic signed [39:0] SL_LO = -40'sd8388608;

    // Table memory, one entry per point.
    logic [63:0] r_mem [MAX_POINTS];
    logic [63:0] r_a, r_b;
    logic [IW-1:0] r_idx;
    logic [4:0]  r_n;
    logic [17:0] r_t;
    logic [1:0]  r_phase;
    logic        r_done, r_special;
    logic signed [18:0] r_val;
    logic [2:0]  r_kind;

    always_ff @(posedge i_clk) begin
        if (i_wr && 32'(i_point_index) < MAX_POINTS)
            r_mem[IW'(i_point_index)] <= {i_point_x, i_point_y, i_tangent_x, i_tangent_y};
    end

    // Scan: read entry 0, entry n-1, then successive pairs.
    logic [17:0] ax, bx;
    assign ax = {2'b0, r_a[63:48]};
    assign bx = {2'b0, r_b[63:48]};
    logic [IW:0] n_last;
    assign n_last = (int'(r_n) > MAX_POINTS) ? (IW+1)'(MAX_POINTS - 1)
                                             : (IW+1)'(r_n - 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_phase <= '0;
        end else if (i_cmd.start) begin
            r_n     <= i_point_count;
            r_t     <= (i_sample_t > 16'd32768) ? 18'd32768 : {2'b0, i_sample_t};
            r_done  <= 1'b0;
            r_phase <= 2'd0;
            r_idx   <= '0;
        end else if (i_cmd.scan && !r_done) begin
            case (r_phase)
                2'd0: begin
                    if (r_n < 5'd2) begin
                        r_done <= 1'b1; r_special <= 1'b1;
                        r_val <= '0; r_kind <= KIND_FEW;
                    end else begin
                        r_a <= r_mem[r_idx];
                        r_b <= r_mem[n_last[IW-1:0]];
                        r_phase <= 2'd1;
                    end
                end
                2'd1: begin
                    if (r_t < ax) begin
                        r_done <= 1'b1; r_special <= 1'b1;
                        r_val <= '0; r_kind <= KIND_BELOW;
                    end else if (r_t > bx) begin
                        r_done <= 1'b1; r_special <= 1'b1;
                        r_val <= 19'sd32768; r_kind <= KIND_ABOVE;
                    end else begin
                        r_b <= r_mem[r_idx + IW'(1)];
                        r_phase <= 2'd2;
                    end
                end
                2'd2: begin
                    if (r_t >= ax && r_t <= bx) begin
                        r_done <= 1'b1;
                        if ($signed(bx - ax) < EPS) begin
                            r_special <= 1'b1;
                            r_val <= $signed({3'b0, r_a[47:32]}); r_kind <= KIND_NARROW;
                        end else begin
                            r_special <= 1'b0; r_kind <= KIND_SEG;
                        end
                    end else if ((IW+1)'(r_idx) + (IW+1)'(2) > n_last) begin
                        r_done <= 1'b1; r_special <= 1'b1;
                        r_val <= $signed({3'b0, r_b[47:32]}); r_kind <= KIND_SEG;
                    end else begin
                        r_a <= r_b;
                        r_b <= r_mem[r_idx + IW'(2)];
                        r_idx <= r_idx + IW'(1);
                    end
                end
                default: r_phase <= 2'd0;
            endcase
        end
    end

    // Three dividers: s and the two end slopes.
    logic signed [39:0] dx, q_s, q_1, q_2, den1, den2;
    logic d0, d1, d2;
    assign dx   = 40'($signed(bx - ax));
    assign den1 = 40'($signed(r_a[31:16])) + 40'(EPS);
    assign den2 = 40'($signed(r_b[31:16])) + 40'(EPS);
    hce_div u_ds (.i_clk, .i_rst_n, .i_start(i_cmd.prep),
        .i_num(40'($signed(r_t - ax)) <<< FB), .i_den(dx), .o_quo(q_s), .o_done(d0));
    hce_div u_d1 (.i_clk, .i_rst_n, .i_start(i_cmd.prep),
        .i_num(40'($signed(r_a[15:0])) <<< FB), .i_den(den1), .o_quo(q_1), .o_done(d1));
    hce_div u_d2 (.i_clk, .i_rst_n, .i_start(i_cmd.prep),
        .i_num(40'($signed(r_b[15:0])) <<< FB), .i_den(den2), .o_quo(q_2), .o_done(d2));

    function automatic logic signed [24:0] slope(input logic signed [39:0] q,
                                                 input logic signed [39:0] den,
                                                 input logic signed [15:0] ty);
        logic signed [39:0] v;
        if (den == 0) v = (ty > 0) ? SL_HI : ((ty < 0) ? SL_LO : 40'sd0);
        else v = (q > SL_HI) ? SL_HI : ((q < SL_LO) ? SL_LO : q);
        return 25'(v);
    endfunction

    assign o_sts.scan_done = r_done;
    assign o_sts.special   = r_special;
    assign o_sts.div_done  = d0 && d1 && d2;

    // Multiply stages.
    logic signed [18:0] r_s;
    logic signed [24:0] r_m1, r_m2;
    logic signed [18:0] r_s2, r_s3;
    logic signed [47:0] p1, p2;
    logic signed [37:0] ps2;
    assign p1  = 48'(slope(q_1, den1, $signed(r_a[15:0]))) * 48'(dx);
    assign p2  = 48'(slope(q_2, den2, $signed(r_b[15:0]))) * 48'(dx);
    assign ps2 = 38'($signed(q_s[18:0])) * 38'($signed(q_s[18:0]));
    logic signed [37:0] ps3;
    assign ps3 = 38'(r_s2) * 38'(r_s);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_s  <= q_s[18:0];
            r_m1 <= 25'(p1 >>> FB);
            r_m2 <= 25'(p2 >>> FB);
            r_s2 <= 19'(ps2 >>> FB);
        end
        if (i_cmd.mul2) r_s3 <= 19'(ps3 >>> FB);
    end

    logic signed [21:0] h1, h2, h3, h4;
    assign h1 = 22'(r_s3) * 22'sd2 - 22'(r_s2) * 22'sd3 + 22'(ONE);
    assign h2 = -22'(r_s3) * 22'sd2 + 22'(r_s2) * 22'sd3;
    assign h3 = 22'(r_s3) - 22'(r_s2) * 22'sd2 + 22'(r_s);
    assign h4 = 22'(r_s3) - 22'(r_s2);
    logic signed [47:0] r_t1, r_t2, r_t3, r_t4, acc;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul3) begin
            r_t1 <= 48'(h1) * 48'($signed({1'b0, r_a[47:32]}));
            r_t2 <= 48'(h2) * 48'($signed({1'b0, r_b[47:32]}));
            r_t3 <= 48'(h3) * 48'(r_m1);
            r_t4 <= 48'(h4) * 48'(r_m2);
        end
    end
    assign acc = (r_t1 + r_t2 + r_t3 + r_t4) >>> FB;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (r_special) o_curve_value <= r_val;
            else if (acc > 48'sd262143) o_curve_value <= 19'sd262143;
            else if (acc < -48'sd262144) o_curve_value <= -19'sd262144;
            else o_curve_value <= 19'(acc);
            o_result_kind <= r_kind;
        end
    end
endmodule

// ----- rtl/hce_ctrl.sv -----
// Controller state machine for the Hermite curve evaluator.
// Depends on hce_pkg.
module hce_ctrl import hce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_mode,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_sts,
    output t_cmd    o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_SCAN = 8'b00000010, S_PREP = 8'b00000100,
        S_DIV  = 8'b00001000, S_M1   = 8'b00010000, S_M2   = 8'b00100000,
        S_M3   = 8'b01000000, S_FIN  = 8'b10000000
    } t_state;
    t_state r_state, n_state;
    logic r_valid;

    assign o_ready = (r_state == S_IDLE) && (!r_valid || i_ready);
    assign o_valid = r_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: if (i_valid && o_ready && i_mode) begin
                o_cmd.start = 1'b1; n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = i_sts.special ? S_FIN : S_PREP;
            end
            S_PREP: begin o_cmd.prep = 1'b1; n_state = S_DIV; end
            S_DIV: if (i_sts.div_done) begin o_cmd.mul1 = 1'b1; n_state = S_M2; end
            S_M2: begin o_cmd.mul2 = 1'b1; n_state = S_M3; end
            S_M3: begin o_cmd.mul3 = 1'b1; n_state = S_FIN; end
            S_FIN: if (!r_valid || i_ready) begin o_cmd.fin = 1'b1; n_state = S_IDLE; end
            S_M1: n_state = S_M2;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.fin) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end
endmodule

// ----- rtl/hermite_curve_evaluator_core.sv -----
// Hermite curve evaluator: a 16-entry point table read as a cubic Hermite curve.
// Output register holds a result while the receiver stalls; a new item can be
// taken once the result is taken or in the same cycle it is taken.
// Input channel: i_valid/o_ready carries mode, point index, point, tangent and t.
// Mode 0 writes one table entry and gives no result.
// Mode 1 gives one result on o_valid/i_ready: curve_value and result_kind.
// Mode 1 path, accepting edge to o_valid: a search testing 1 to MAX_POINTS-1
// segments, the start of the three bit-serial dividers (s and both slopes),
// the divide and the first multiply stage, two more multiply stages and the
// output load. Fewer than two points, t outside the table, a narrow segment or
// no segment go from the search straight to the output load.
// One evaluation at a time; the next item is taken once the result is loaded and the receiver takes it.
// Configuration: i_cfg_valid/o_cfg_ready writes point_count; always ready.
// Reset clears the state machine, output valid and point_count; the table
// holds nothing defined until written.
// Depends on hce_pkg, hce_ctrl, hce_datapath, hce_div.
module hermite_curve_evaluator_core import hce_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [3:0]         i_point_index,
    input  logic [15:0]        i_point_x,
    input  logic [15:0]        i_point_y,
    input  logic signed [15:0] i_tangent_x,
    input  logic signed [15:0] i_tangent_y,
    input  logic [15:0]        i_sample_t,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [18:0] o_curve_value,
    output logic [2:0]         o_result_kind,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_data
);
    logic [4:0] r_point_count;
    t_cmd    w_cmd;
    t_status w_sts;

    assign o_cfg_ready = 1'b1;
    // Register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_point_count <= '0;
        else if (i_cfg_valid) r_point_count <= i_cfg_data;
    end

    hce_ctrl u_ctrl (.i_clk, .i_rst_n, .i_valid, .i_mode, .o_ready, .o_valid,
        .i_ready, .i_sts(w_sts), .o_cmd(w_cmd));

    hce_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (.i_clk, .i_rst_n,
        .i_wr(i_valid && o_ready && !i_mode), .i_point_index, .i_point_x,
        .i_point_y, .i_tangent_x, .i_tangent_y, .i_sample_t,
        .i_point_count(r_point_count), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_curve_value, .o_result_kind);

    // A held result must not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_curve_value) && $stable(o_result_kind))
        else $error("result changed under stall");
    // No new item is taken while the segment scan runs.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan |-> !o_ready) else $error("accepted while busy");
    // Result kind is within its codes when shown.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result_kind <= KIND_FEW) else $error("bad kind");
endmodule
